// File: rtl/mtes_pkg.sv
// ----------------------------------------------------------------------------
// mtes_pkg
// Shared widths, command codes and byte constants for the MIDI track event
// serializer.
// ----------------------------------------------------------------------------
package mtes_pkg;

    localparam int CMD_W   = 2;
    localparam int TICK_W  = 32;
    localparam int CHAN_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int GRP_W   = 7;

    localparam logic [CMD_W-1:0] CMD_NOTE_ON      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END_OF_TRACK = 2'd2;

    localparam logic [BYTE_W-1:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [BYTE_W-1:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [BYTE_W-1:0] NOTE_MAX        = 8'd127;
    localparam logic [BYTE_W-1:0] VLQ_CONT        = 8'h80;
    localparam logic [BYTE_W-1:0] META_PREFIX     = 8'hFF;
    localparam logic [BYTE_W-1:0] META_EOT        = 8'h2F;

    // 00 FF 2F 00
    function automatic logic [BYTE_W-1:0] eot_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd1:    b = META_PREFIX;
            2'd2:    b = META_EOT;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/mtes_if.sv
// ----------------------------------------------------------------------------
// mtes_if
// Valid/ready channels: note event input and encoded byte output.
// ----------------------------------------------------------------------------
interface mtes_evt_if
    import mtes_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TICK_W-1:0] event_tick;
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] note;
    logic [BYTE_W-1:0] velocity;

    modport source (
        output valid, command, event_tick, channel, note, velocity,
        input  ready
    );
    modport sink (
        input  valid, command, event_tick, channel, note, velocity,
        output ready
    );
endinterface

interface mtes_byte_if
    import mtes_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_event;

    modport source (
        output valid, out_byte, last_of_event,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last_of_event,
        output ready
    );
endinterface

// File: rtl/midi_track_event_serializer.sv
// Order: the delta is scanned one 7-bit group at a time (1 to 5 groups),
//   then the first byte is registered.
// Throughput: one output byte per cycle while the output is not stalled; an
//   event holds the input through scan, VLQ bytes, status slot, note, velocity.
// Reset: synchronous active-low i_rst_n clears previous tick, running status,
//   the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
// midi_track_event_serializer
// Encodes sorted note events into SMF track bytes: VLQ delta tick, status
// with running status, note and velocity; end of track emits 00 FF 2F 00; other events are dropped.
// ----------------------------------------------------------------------------
module midi_track_event_serializer
    import mtes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtes_evt_if.sink    i_evt,
    mtes_byte_if.source o_byte
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_VLQ,
        S_STATUS,
        S_NOTE,
        S_VEL,
        S_EOT
    } t_state;

    t_state             r_state,   n_state;
    logic [TICK_W-1:0]  r_prev,    n_prev;
    logic [BYTE_W-1:0]  r_running, n_running;
    logic [TICK_W-1:0]  r_delta,   n_delta;
    logic [TICK_W-1:0]  r_scan,    n_scan;
    logic [2:0]         r_ngrp,    n_ngrp;
    logic [2:0]         r_idx,     n_idx;
    logic [1:0]         r_eot_cnt, n_eot_cnt;
    logic [BYTE_W-1:0]  r_status,  n_status;
    logic [BYTE_W-1:0]  r_note,    n_note;
    logic [BYTE_W-1:0]  r_vel,     n_vel;
    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_out_byte,  n_out_byte;
    logic               r_out_last,  n_out_last;

    logic               w_accept;
    logic               w_can_emit;
    logic [GRP_W-1:0]   w_group;

    assign i_evt.ready          = (r_state == S_IDLE);
    assign w_accept             = i_evt.valid && i_evt.ready;
    assign w_can_emit           = !r_out_valid || o_byte.ready;
    assign o_byte.valid         = r_out_valid;
    assign o_byte.out_byte      = r_out_byte;
    assign o_byte.last_of_event = r_out_last;

    always_comb begin
        case (r_idx)
            3'd0:    w_group = r_delta[6:0];
            3'd1:    w_group = r_delta[13:7];
            3'd2:    w_group = r_delta[20:14];
            3'd3:    w_group = r_delta[27:21];
            3'd4:    w_group = {3'b000, r_delta[31:28]};
            default: w_group = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_running   = r_running;
        n_delta     = r_delta;
        n_scan      = r_scan;
        n_ngrp      = r_ngrp;
        n_idx       = r_idx;
        n_eot_cnt   = r_eot_cnt;
        n_status    = r_status;
        n_note      = r_note;
        n_vel       = r_vel;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (r_out_valid && o_byte.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_note = i_evt.note;
                    n_vel  = i_evt.velocity;
                    n_status = ((i_evt.command == CMD_NOTE_ON) ? STATUS_NOTE_ON
                                                               : STATUS_NOTE_OFF)
                               | {4'h0, i_evt.channel};
                    n_eot_cnt = 2'd0;
                    if (i_evt.command == CMD_END_OF_TRACK) begin
                        n_state = S_EOT;
                    end else if ((i_evt.command == CMD_NOTE_ON ||
                                  i_evt.command == CMD_NOTE_OFF) &&
                                 i_evt.note <= NOTE_MAX) begin
                        n_delta = i_evt.event_tick - r_prev;
                        n_scan  = (i_evt.event_tick - r_prev) >> GRP_W;
                        n_prev  = i_evt.event_tick;
                        n_ngrp  = 3'd1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_scan != '0) begin
                    n_scan = r_scan >> GRP_W;
                    n_ngrp = r_ngrp + 3'd1;
                end else begin
                    n_idx   = r_ngrp - 3'd1;
                    n_state = S_VLQ;
                end
            end
            S_VLQ: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b0;
                    n_out_byte  = {1'b0, w_group} | ((r_idx != 3'd0) ? VLQ_CONT : 8'h00);
                    if (r_idx == 3'd0) begin
                        n_state = S_STATUS;
                    end else begin
                        n_idx = r_idx - 3'd1;
                    end
                end
            end
            S_STATUS: begin
                if (r_status != r_running || r_running == 8'h00) begin
                    if (w_can_emit) begin
                        n_out_valid = 1'b1;
                        n_out_last  = 1'b0;
                        n_out_byte  = r_status;
                        n_running   = r_status;
                        n_state     = S_NOTE;
                    end
                end else begin
                    n_state = S_NOTE;
                end
            end
            S_NOTE: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b0;
                    n_out_byte  = r_note;
                    n_state     = S_VEL;
                end
            end
            S_VEL: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_byte  = r_vel;
                    n_state     = S_IDLE;
                end
            end
            S_EOT: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = eot_byte(r_eot_cnt);
                    n_out_last  = (r_eot_cnt == 2'd3);
                    n_eot_cnt   = r_eot_cnt + 2'd1;
                    if (r_eot_cnt == 2'd3) begin
                        n_prev    = '0;
                        n_running = '0;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_running   <= '0;
            r_out_valid <= 1'b0;
            r_ngrp      <= 3'd0;
            r_idx       <= 3'd0;
            r_eot_cnt   <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
            r_ngrp      <= n_ngrp;
            r_idx       <= n_idx;
            r_eot_cnt   <= n_eot_cnt;
        end
        r_delta    <= n_delta;
        r_scan     <= n_scan;
        r_status   <= n_status;
        r_note     <= n_note;
        r_vel      <= n_vel;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

`ifndef ASSERT_OFF
    a_grp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VLQ) |-> (r_idx <= 3'd4 && r_idx < r_ngrp))
        else $error("VLQ group index out of range");

    a_running_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running == 8'h00) || r_running[7])
        else $error("running status is not a status byte");

    a_vel_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VEL && w_can_emit) |=>
            (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("velocity byte not flagged last");

    a_eot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EOT && w_can_emit && r_eot_cnt == 2'd3) |=>
            (r_prev == '0 && r_running == 8'h00 && r_state == S_IDLE))
        else $error("end of track did not clear state");
`endif

endmodule
